// ----- rtl/core/touch_keypad_event_generator_macros.svh -----
// assertion helpers used by touch_keypad_event_generator.sv
`ifndef TOUCH_KEYPAD_EVENT_GENERATOR_MACROS_SVH
`define TOUCH_KEYPAD_EVENT_GENERATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define TKEG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tkeg assertion failed");

// next-cycle implication, disabled during reset
`define TKEG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tkeg assertion failed");

`endif

// ----- rtl/core/tkeg_pkg.sv -----
package tkeg_pkg;

   localparam int GRID_ROWS = 6;
   localparam int GRID_COLS = 4;
   localparam int SPLIT_ROW = 4;

   localparam int TIME_W = 32;
   localparam int POS_W = 11;
   localparam int KEY_W = 5;
   localparam int ACT_W = 2;
   localparam int COUNT_W = 5;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   // wide enough for origin + 5 pitches + split gap + button size
   localparam int COORD_W = 14;
   localparam int ROW_W = $clog2(GRID_ROWS + 1);
   localparam int COL_W = $clog2(GRID_COLS + 1);
   localparam int KEY_FULL_W = $clog2(GRID_ROWS * GRID_COLS + 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [ACT_W-1:0] {
      ACT_DOWN = 2'd0,
      ACT_LONG = 2'd1,
      ACT_UP   = 2'd2
   } act_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X   = 3'd0,
      CSR_ORIGIN_Y   = 3'd1,
      CSR_BTN_WIDTH  = 3'd2,
      CSR_BTN_HEIGHT = 3'd3,
      CSR_SPACING    = 3'd4,
      CSR_DEBOUNCE   = 3'd5,
      CSR_LONG_PRESS = 3'd6
   } csr_idx_type;

   localparam logic [POS_W-1:0] RST_ORIGIN_X = 11'd642;
   localparam logic [POS_W-1:0] RST_ORIGIN_Y = 11'd0;
   localparam logic [7:0] RST_BTN_WIDTH = 8'd88;
   localparam logic [7:0] RST_BTN_HEIGHT = 8'd93;
   localparam logic [5:0] RST_SPACING = 6'd5;
   localparam logic [15:0] RST_DEBOUNCE = 16'd20;
   localparam logic [15:0] RST_LONG_PRESS = 16'd500;

   typedef struct packed {
      logic [POS_W-1:0] origin_x;
      logic [POS_W-1:0] origin_y;
      logic [7:0]       btn_width;
      logic [7:0]       btn_height;
      logic [5:0]       spacing;
      logic [15:0]      debounce;
      logic [15:0]      long_press;
   } cfg_type;

   // one classified tick
   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      logic              irq;
      logic              touch;
      logic              hit;
      logic [KEY_W-1:0]  key;
   } q_item_type;

   typedef struct packed {
      logic valid;
      logic full;
   } q_stat_type;

   typedef struct packed {
      logic    pop;
      logic    emit;
      act_type act;
      logic    sel_valid;
   } back_stat_type;

endpackage

// ----- rtl/core/tkeg_front.sv -----
module tkeg_front (
   input  tkeg_pkg::cfg_type              cfg,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [tkeg_pkg::TIME_W-1:0]    req_now_ms,
   input  logic                           req_touch_irq,
   input  logic [tkeg_pkg::COUNT_W-1:0]   req_touch_count,
   input  logic [tkeg_pkg::POS_W-1:0]     req_touch_x,
   input  logic [tkeg_pkg::POS_W-1:0]     req_touch_y,
   input  tkeg_pkg::q_stat_type           q_stat,
   output logic                           push,
   output tkeg_pkg::q_item_type           push_item
);
   import tkeg_pkg::*;

   logic [COORD_W-1:0]    pitch_x;
   logic [COORD_W-1:0]    pitch_y;
   logic [COORD_W-1:0]    split_gap;
   logic [COORD_W-1:0]    px;
   logic [COORD_W-1:0]    py;
   logic [COORD_W-1:0]    row_top [GRID_ROWS];
   logic [COORD_W-1:0]    col_left [GRID_COLS];
   logic [GRID_ROWS-1:0]  row_hit;
   logic [GRID_COLS-1:0]  col_hit;
   logic [ROW_W-1:0]      first_r;
   logic [COL_W-1:0]      first_c;
   logic [KEY_FULL_W-1:0] key_full;

   assign req_ready = !q_stat.full;
   assign push = req_valid && !q_stat.full;

   assign pitch_x = COORD_W'(cfg.btn_width) + COORD_W'(cfg.spacing);
   assign pitch_y = COORD_W'(cfg.btn_height) + COORD_W'(cfg.spacing);
   assign split_gap = COORD_W'(cfg.spacing) << 1;
   assign px = COORD_W'(req_touch_x);
   assign py = COORD_W'(req_touch_y);

   // button edges, strict compare on both sides
   always_comb begin
      for (int r = 0; r < GRID_ROWS; r++) begin
         row_top[r] = COORD_W'(cfg.origin_y) + COORD_W'(r) * pitch_y
                      + ((r >= SPLIT_ROW) ? split_gap : '0);
         row_hit[r] = (py > row_top[r]) && (py < row_top[r] + COORD_W'(cfg.btn_height));
      end
      for (int c = 0; c < GRID_COLS; c++) begin
         col_left[c] = COORD_W'(cfg.origin_x) + COORD_W'(c) * pitch_x
                       + ((c >= 1) ? split_gap : '0);
         col_hit[c] = (px > col_left[c]) && (px < col_left[c] + COORD_W'(cfg.btn_width));
      end
   end

   // lowest row and column win
   always_comb begin
      first_r = '0;
      for (int r = GRID_ROWS - 1; r >= 0; r--) begin
         if (row_hit[r]) begin
            first_r = ROW_W'(r);
         end
      end
      first_c = '0;
      for (int c = GRID_COLS - 1; c >= 0; c--) begin
         if (col_hit[c]) begin
            first_c = COL_W'(c);
         end
      end
   end

   assign key_full = KEY_FULL_W'(first_r) * KEY_FULL_W'(GRID_COLS) + KEY_FULL_W'(first_c);

   always_comb begin
      push_item.now_ms = req_now_ms;
      push_item.irq = req_touch_irq;
      push_item.touch = (req_touch_count != '0);
      push_item.hit = (|row_hit) && (|col_hit);
      push_item.key = KEY_W'(key_full);
   end

endmodule

// ----- rtl/core/tkeg_queue.sv -----
module tkeg_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  tkeg_pkg::q_item_type  push_item,
   input  logic                  pop,
   output tkeg_pkg::q_item_type  pop_item,
   output tkeg_pkg::q_stat_type  stat
);
   import tkeg_pkg::*;

   q_item_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff;
   logic [QCNT_W-1:0]  count_in;

   assign stat.valid = (count_ff != '0);
   assign stat.full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/core/tkeg_back.sv -----
module tkeg_back (
   input  logic                          clock,
   input  logic                          reset,
   input  tkeg_pkg::cfg_type             cfg,
   input  tkeg_pkg::q_stat_type          q_stat,
   input  tkeg_pkg::q_item_type          q_item,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tkeg_pkg::KEY_W-1:0]    rsp_key_index,
   output logic [tkeg_pkg::ACT_W-1:0]    rsp_key_action,
   output tkeg_pkg::back_stat_type       bstat
);
   import tkeg_pkg::*;

   logic              pending_ff;
   logic              pending_in;
   logic [TIME_W-1:0] last_ff;
   logic [TIME_W-1:0] last_in;
   logic              sel_valid_ff;
   logic              sel_valid_in;
   logic [KEY_W-1:0]  sel_key_ff;
   logic [KEY_W-1:0]  sel_key_in;
   logic [TIME_W-1:0] press_ff;
   logic [TIME_W-1:0] press_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [KEY_W-1:0]  rsp_key_ff;
   logic [KEY_W-1:0]  rsp_key_in;
   act_type           rsp_act_ff;
   act_type           rsp_act_in;

   logic              pend_now;
   logic [TIME_W-1:0] since_last;
   logic [TIME_W-1:0] since_press;
   logic              emit;
   logic [KEY_W-1:0]  emit_key;
   act_type           emit_act;

   assign pop = q_stat.valid && (!rsp_valid_ff || rsp_ready);
   assign pend_now = pending_ff || q_item.irq;
   assign since_last = q_item.now_ms - last_ff;
   assign since_press = q_item.now_ms - press_ff;

   always_comb begin
      pending_in = pending_ff;
      last_in = last_ff;
      sel_valid_in = sel_valid_ff;
      sel_key_in = sel_key_ff;
      press_in = press_ff;
      emit = 1'b0;
      emit_key = q_item.key;
      emit_act = ACT_DOWN;
      if (pop) begin
         if (since_last < TIME_W'(cfg.debounce)) begin
            // report latched, tick otherwise ignored
            pending_in = pend_now;
         end else if (pend_now) begin
            pending_in = 1'b0;
            last_in = q_item.now_ms;
            if (q_item.touch && q_item.hit) begin
               if (sel_valid_ff && (sel_key_ff == q_item.key)) begin
                  if (since_press > TIME_W'(cfg.long_press)) begin
                     emit = 1'b1;
                     emit_act = ACT_LONG;
                     sel_valid_in = 1'b0;
                     sel_key_in = '0;
                     press_in = '0;
                  end
               end else begin
                  emit = 1'b1;
                  emit_act = ACT_DOWN;
                  sel_valid_in = 1'b1;
                  sel_key_in = q_item.key;
                  press_in = q_item.now_ms;
               end
            end
         end else if (sel_valid_ff) begin
            emit = 1'b1;
            emit_key = sel_key_ff;
            emit_act = ACT_UP;
            sel_valid_in = 1'b0;
            sel_key_in = '0;
            press_in = '0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_key_in = rsp_key_ff;
      rsp_act_in = rsp_act_ff;
      if (pop) begin
         rsp_valid_in = emit;
         rsp_key_in = emit_key;
         rsp_act_in = emit_act;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         last_ff <= '0;
         sel_valid_ff <= 1'b0;
         sel_key_ff <= '0;
         press_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         last_ff <= last_in;
         sel_valid_ff <= sel_valid_in;
         sel_key_ff <= sel_key_in;
         press_ff <= press_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_key_ff <= rsp_key_in;
      rsp_act_ff <= rsp_act_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_key_index = rsp_key_ff;
   assign rsp_key_action = rsp_act_ff;

   always_comb begin
      bstat.pop = pop;
      bstat.emit = emit;
      bstat.act = emit_act;
      bstat.sel_valid = sel_valid_ff;
   end

endmodule

// ----- rtl/core/touch_keypad_event_generator.sv -----
// touch keypad event generator
// req_ channel: one update tick per item (time, report flag, touch count, first
// touch point). rsp_ channel: zero or one key event per tick, key_index and
// key_action (0 down, 1 long press, 2 up). csr_ channel: register writes by
// index, always ready, to be done while no tick is in flight.
// the front hit-tests each tick combinationally and pushes it into a two-entry
// queue in the cycle it is accepted; the back pops one entry per cycle unless
// rsp_ is stalled, updates the debounce and selection state and loads the
// output register. an event is registered in a queue entry and then in the
// output register before it is valid on rsp_. throughput: one tick per cycle
// while rsp_ is not stalled; ticks that cause no event still take a back pop.
// a stalled rsp_ holds its event; the back then waits, the queue fills and
// req_ready drops once both entries are occupied.
// reset (synchronous, active high) restores the register defaults, clears the
// pending report, the selection, both timestamps, the queue and the output.
`include "touch_keypad_event_generator_macros.svh"

module touch_keypad_event_generator (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [tkeg_pkg::TIME_W-1:0]            req_now_ms,
   input  logic                                   req_touch_irq,
   input  logic [tkeg_pkg::COUNT_W-1:0]           req_touch_count,
   input  logic [tkeg_pkg::POS_W-1:0]             req_touch_x,
   input  logic [tkeg_pkg::POS_W-1:0]             req_touch_y,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [tkeg_pkg::KEY_W-1:0]             rsp_key_index,
   output logic [tkeg_pkg::ACT_W-1:0]             rsp_key_action,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [tkeg_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [tkeg_pkg::CSR_DATA_W-1:0]        csr_data
);
   import tkeg_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   q_stat_type    q_stat;
   q_item_type    push_item;
   q_item_type    pop_item;
   logic          push;
   logic          pop;
   back_stat_type bstat;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_ORIGIN_X:   cfg_in.origin_x = csr_data[POS_W-1:0];
            CSR_ORIGIN_Y:   cfg_in.origin_y = csr_data[POS_W-1:0];
            CSR_BTN_WIDTH:  cfg_in.btn_width = csr_data[7:0];
            CSR_BTN_HEIGHT: cfg_in.btn_height = csr_data[7:0];
            CSR_SPACING:    cfg_in.spacing = csr_data[5:0];
            CSR_DEBOUNCE:   cfg_in.debounce = csr_data;
            CSR_LONG_PRESS: cfg_in.long_press = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x <= RST_ORIGIN_X;
         cfg_ff.origin_y <= RST_ORIGIN_Y;
         cfg_ff.btn_width <= RST_BTN_WIDTH;
         cfg_ff.btn_height <= RST_BTN_HEIGHT;
         cfg_ff.spacing <= RST_SPACING;
         cfg_ff.debounce <= RST_DEBOUNCE;
         cfg_ff.long_press <= RST_LONG_PRESS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tkeg_front u_front (
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_now_ms      (req_now_ms),
      .req_touch_irq   (req_touch_irq),
      .req_touch_count (req_touch_count),
      .req_touch_x     (req_touch_x),
      .req_touch_y     (req_touch_y),
      .q_stat          (q_stat),
      .push            (push),
      .push_item       (push_item)
   );

   tkeg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .stat      (q_stat)
   );

   tkeg_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_stat         (q_stat),
      .q_item         (pop_item),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_key_index  (rsp_key_index),
      .rsp_key_action (rsp_key_action),
      .bstat          (bstat)
   );

   // the back never pops an empty queue nor overwrites a stalled event
   `TKEG_ASSERT_NOW(a_pop_valid, clock, reset, bstat.pop, q_stat.valid && (!rsp_valid || rsp_ready))
   // down leaves a selection behind, long and up clear it
   `TKEG_ASSERT_NEXT(a_down_sel, clock, reset, bstat.pop && bstat.emit && (bstat.act == ACT_DOWN), bstat.sel_valid)
   `TKEG_ASSERT_NEXT(a_clear_sel, clock, reset, bstat.pop && bstat.emit && (bstat.act != ACT_DOWN), !bstat.sel_valid)
   // an up event always comes from an existing selection
   `TKEG_ASSERT_NOW(a_up_from_sel, clock, reset, bstat.pop && bstat.emit && (bstat.act == ACT_UP), bstat.sel_valid)

endmodule

// ----- dv/touch_keypad_event_generator_tb.sv -----
`timescale 1ns / 1ps

module touch_keypad_event_generator_tb;
   import tkeg_pkg::*;

   typedef struct packed {
      logic [TIME_W-1:0]  now_ms;
      logic               irq;
      logic [COUNT_W-1:0] count;
      logic [POS_W-1:0]   x;
      logic [POS_W-1:0]   y;
   } tick_t;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      act_type          act;
   } key_event_t;

   typedef struct {
      tick_t      tick;
      bit         typed;
      bit         emits;
      key_event_t ev;
   } row_t;

   localparam int RANDOM_PHASES = 8;
   localparam int TICKS_PER_PHASE = 210;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [TIME_W-1:0] req_now_ms = '0;
   logic req_touch_irq = 1'b0;
   logic [COUNT_W-1:0] req_touch_count = '0;
   logic [POS_W-1:0] req_touch_x = '0;
   logic [POS_W-1:0] req_touch_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [KEY_W-1:0] rsp_key_index;
   logic [ACT_W-1:0] rsp_key_action;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // hand-typed expectation travels with the item it belongs to
   bit check_typed = 1'b0;
   bit typed_emits = 1'b0;
   key_event_t typed_ev = '0;

   // keypad state as this bench sees it
   cfg_type keypad_cfg;
   logic report_waiting;
   logic [TIME_W-1:0] last_handled_ms;
   logic key_held;
   logic [KEY_W-1:0] held_key;
   logic [TIME_W-1:0] held_since_ms;

   key_event_t key_events_due [$];
   cfg_type active_setting;
   logic [TIME_W-1:0] stim_clock_ms = '0;
   int aim_row = 0;
   int aim_col = 0;
   int burst_left = 0;
   int failures = 0;
   int ticks_accepted = 0;
   int ticks_handled = 0;
   int settings_applied = 0;
   int act_count [3] = '{0, 0, 0};
   row_t directed_rows [20];
   key_event_t no_event = '0;

   touch_keypad_event_generator i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_now_ms      (req_now_ms),
      .req_touch_irq   (req_touch_irq),
      .req_touch_count (req_touch_count),
      .req_touch_x     (req_touch_x),
      .req_touch_y     (req_touch_y),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_key_index   (rsp_key_index),
      .rsp_key_action  (rsp_key_action),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(10_000_000);
      $display("run did not complete in time");
      $display("touch_keypad_event_generator_tb: errors");
      $finish;
   end

   // strict inequalities on both edges, first hit in row-major order
   function automatic bit locate_button(input logic [POS_W-1:0] px, py,
                                        output logic [KEY_W-1:0] key);
      int r, c, top, left, ox, oy, w, h, s;
      ox = int'(keypad_cfg.origin_x);
      oy = int'(keypad_cfg.origin_y);
      w = int'(keypad_cfg.btn_width);
      h = int'(keypad_cfg.btn_height);
      s = int'(keypad_cfg.spacing);
      key = '0;
      for (r = 0; r < GRID_ROWS; r++) begin
         top = oy + r * (h + s);
         if (r >= SPLIT_ROW) top += 2 * s;
         if (!(int'(py) > top && int'(py) < top + h)) continue;
         for (c = 0; c < GRID_COLS; c++) begin
            left = ox + c * (w + s);
            if (c >= 1) left += 2 * s;
            if (int'(px) > left && int'(px) < left + w) begin
               key = KEY_W'(r * GRID_COLS + c);
               return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic bit key_event_for_tick(input tick_t t, output key_event_t ev);
      logic [KEY_W-1:0] key;
      logic [TIME_W-1:0] since_handled, held_for;
      bit fires;
      ev = '0;
      fires = 1'b0;
      if (t.irq) report_waiting = 1'b1;
      since_handled = t.now_ms - last_handled_ms;
      if (since_handled < TIME_W'(keypad_cfg.debounce)) return 1'b0;
      ticks_handled++;
      if (report_waiting) begin
         if (t.count != 0 && locate_button(t.x, t.y, key)) begin
            if (key_held && held_key == key) begin
               held_for = t.now_ms - held_since_ms;
               if (held_for > TIME_W'(keypad_cfg.long_press)) begin
                  ev = '{key, ACT_LONG};
                  key_held = 1'b0;
                  held_key = '0;
                  held_since_ms = '0;
                  fires = 1'b1;
               end
            end else begin
               // a different button replaces the selection without an up
               key_held = 1'b1;
               held_key = key;
               held_since_ms = t.now_ms;
               ev = '{key, ACT_DOWN};
               fires = 1'b1;
            end
         end
         report_waiting = 1'b0;
         last_handled_ms = t.now_ms;
         return fires;
      end
      if (key_held) begin
         ev = '{held_key, ACT_UP};
         key_held = 1'b0;
         held_key = '0;
         held_since_ms = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   always @(posedge clock) begin : monitor
      key_event_t predicted, due;
      bit fires;
      if (reset) begin
         keypad_cfg = '{RST_ORIGIN_X, RST_ORIGIN_Y, RST_BTN_WIDTH, RST_BTN_HEIGHT,
                        RST_SPACING, RST_DEBOUNCE, RST_LONG_PRESS};
         report_waiting = 1'b0;
         last_handled_ms = '0;
         key_held = 1'b0;
         held_key = '0;
         held_since_ms = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_idx_type'(csr_index))
               CSR_ORIGIN_X:   keypad_cfg.origin_x = csr_data[POS_W-1:0];
               CSR_ORIGIN_Y:   keypad_cfg.origin_y = csr_data[POS_W-1:0];
               CSR_BTN_WIDTH:  keypad_cfg.btn_width = csr_data[7:0];
               CSR_BTN_HEIGHT: keypad_cfg.btn_height = csr_data[7:0];
               CSR_SPACING:    keypad_cfg.spacing = csr_data[5:0];
               CSR_DEBOUNCE:   keypad_cfg.debounce = csr_data;
               CSR_LONG_PRESS: keypad_cfg.long_press = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            fires = key_event_for_tick('{req_now_ms, req_touch_irq, req_touch_count,
                                         req_touch_x, req_touch_y}, predicted);
            if (check_typed) begin
               fires = typed_emits;
               predicted = typed_ev;
            end
            if (fires) key_events_due.push_back(predicted);
            ticks_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (key_events_due.size() == 0) begin
               $error("key event with nothing expected: key_index %0d key_action %0d",
                      rsp_key_index, rsp_key_action);
               failures++;
            end else begin
               due = key_events_due.pop_front();
               if (rsp_key_index !== due.key) begin
                  $error("key_index: expected %0d, got %0d", due.key, rsp_key_index);
                  failures++;
               end
               if (rsp_key_action !== due.act) begin
                  $error("key_action: expected %0d, got %0d", due.act, rsp_key_action);
                  failures++;
               end
               act_count[due.act]++;
            end
         end
      end
   end

   // receiver: picks a new stall style whenever its random stall counter runs out
   always @(posedge clock) begin : rsp_stall
      static int stall_mode = 0;
      static int stall_left = 0;
      static int stall_tick = 0;
      stall_tick++;
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(50, 300);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= (stall_tick % 4 == 0);
         default: rsp_ready <= ($urandom_range(0, 9) != 0);
      endcase
   end

   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 8);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic offer_tick(input tick_t t, input bit typed, input bit emits,
                             input key_event_t ev);
      pace_sender();
      req_valid <= 1'b1;
      req_now_ms <= t.now_ms;
      req_touch_irq <= t.irq;
      req_touch_count <= t.count;
      req_touch_x <= t.x;
      req_touch_y <= t.y;
      check_typed <= typed;
      typed_emits <= emits;
      typed_ev <= ev;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic apply_setting(input cfg_type s);
      active_setting = s;
      write_reg(CSR_ORIGIN_X, CSR_DATA_W'(s.origin_x));
      write_reg(CSR_ORIGIN_Y, CSR_DATA_W'(s.origin_y));
      write_reg(CSR_BTN_WIDTH, CSR_DATA_W'(s.btn_width));
      write_reg(CSR_BTN_HEIGHT, CSR_DATA_W'(s.btn_height));
      write_reg(CSR_SPACING, CSR_DATA_W'(s.spacing));
      write_reg(CSR_DEBOUNCE, s.debounce);
      write_reg(CSR_LONG_PRESS, s.long_press);
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   // drain outstanding key events, then give silent ticks time to leave the pipe
   task automatic settle();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      burst_left = 0;
      while (key_events_due.size() != 0 && waited < 4000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (key_events_due.size() != 0) begin
         $error("%0d key events never arrived", key_events_due.size());
         failures += key_events_due.size();
         key_events_due.delete();
      end
   endtask

   function automatic cfg_type pick_setting(input int p);
      cfg_type s;
      case (p)
         0: s = '{RST_ORIGIN_X, RST_ORIGIN_Y, RST_BTN_WIDTH, RST_BTN_HEIGHT,
                  RST_SPACING, RST_DEBOUNCE, RST_LONG_PRESS};
         1: s = '{11'd0, 11'd0, 8'd255, 8'd255, 6'd0, 16'd0, 16'd0};
         2: s = '{11'd2047, 11'd2047, 8'd1, 8'd1, 6'd63, 16'hffff, 16'hffff};
         // one-pixel hit area per button
         3: s = '{11'd10, 11'd20, 8'd2, 8'd2, 6'd63, 16'd1, 16'd1};
         default: begin
            s.origin_x = POS_W'($urandom_range(0, 700));
            s.origin_y = POS_W'($urandom_range(0, 600));
            s.btn_width = 8'($urandom_range(2, 255));
            s.btn_height = 8'($urandom_range(2, 255));
            s.spacing = 6'($urandom_range(0, 63));
            s.debounce = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 60))
                                                     : 16'($urandom_range(0, 65535));
            s.long_press = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                       : 16'($urandom_range(0, 2000));
         end
      endcase
      return s;
   endfunction

   // mostly presses and holds on real buttons, with releases and noise mixed in
   function automatic tick_t make_tick();
      tick_t t;
      int unsigned dbn, lp, advance;
      int w, h, s, left, top, x, y, dice, kind;
      dbn = active_setting.debounce;
      lp = active_setting.long_press;
      w = int'(active_setting.btn_width);
      h = int'(active_setting.btn_height);
      s = int'(active_setting.spacing);
      dice = $urandom_range(0, 99);
      if (dice < 45) advance = $urandom_range(0, dbn + 40);
      else if (dice < 80) advance = $urandom_range(0, lp + 100);
      else if (dice < 90) begin
         case ($urandom_range(0, 3))
            0: advance = dbn;
            1: advance = (dbn == 0) ? 0 : dbn - 1;
            2: advance = lp;
            default: advance = lp + 1;
         endcase
      end else advance = $urandom();
      stim_clock_ms += advance;
      if ($urandom_range(0, 99) < 40) begin
         aim_row = $urandom_range(0, GRID_ROWS - 1);
         aim_col = $urandom_range(0, GRID_COLS - 1);
      end
      left = int'(active_setting.origin_x) + aim_col * (w + s) + ((aim_col >= 1) ? 2 * s : 0);
      top = int'(active_setting.origin_y) + aim_row * (h + s)
            + ((aim_row >= SPLIT_ROW) ? 2 * s : 0);
      x = left + ((w >= 2) ? int'($urandom_range(1, w - 1)) : 0);
      y = top + ((h >= 2) ? int'($urandom_range(1, h - 1)) : 0);
      if (x > 2047) x = $urandom_range(0, 2047);
      if (y > 2047) y = $urandom_range(0, 2047);
      t.now_ms = stim_clock_ms;
      t.irq = 1'b1;
      t.count = COUNT_W'($urandom_range(1, 31));
      t.x = x[POS_W-1:0];
      t.y = y[POS_W-1:0];
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
         t.irq = ($urandom_range(0, 9) != 0);
      end else if (kind < 72) begin
         t.irq = 1'b0;
         t.count = COUNT_W'($urandom_range(0, 31));
         t.x = POS_W'($urandom_range(0, 2047));
         t.y = POS_W'($urandom_range(0, 2047));
      end else if (kind < 80) begin
         t.count = '0;
      end else if (kind < 90) begin
         t.x = POS_W'($urandom_range(0, 2047));
         t.y = POS_W'($urandom_range(0, 2047));
      end else begin
         // exactly on an edge, which must miss
         if ($urandom_range(0, 1) != 0) begin
            x = ($urandom_range(0, 1) != 0) ? left : left + w;
            if (x <= 2047) t.x = x[POS_W-1:0];
         end else begin
            y = ($urandom_range(0, 1) != 0) ? top : top + h;
            if (y <= 2047) t.y = y[POS_W-1:0];
         end
      end
      return t;
   endfunction

   initial begin : stimulus
      int p, tries;
      // reset geometry: column 0 spans x 642..730, row 0 y 0..93, row 5 col 3 is key 23
      directed_rows = '{
         '{'{32'd5, 1'b1, 5'd1, 11'd700, 11'd50}, 1'b1, 1'b0, '{5'd0, ACT_DOWN}},
         '{'{32'd30, 1'b0, 5'd1, 11'd700, 11'd50}, 1'b0, 1'b0, '{5'd0, ACT_DOWN}},
         '{'{32'd40, 1'b1, 5'd1, 11'd700, 11'd50}, 1'b0, 1'b0, '{5'd0, ACT_DOWN}},
         '{'{32'd60, 1'b0, 5'd1, 11'd700, 11'd50}, 1'b0, 1'b0, '{5'd0, ACT_DOWN}},
         '{'{32'd600, 1'b1, 5'd1, 11'd700, 11'd50}, 1'b0, 1'b0, '{5'd0, ACT_DOWN}},
         '{'{32'd700, 1'b0, 5'd0, 11'd0, 11'd0}, 1'b0, 1'b0, '{5'd0, ACT_DOWN}},
         '{'{32'd800, 1'b1, 5'd31, 11'd1018, 11'd602}, 1'b0, 1'b0, '{5'd0, ACT_DOWN}},
         '{'{32'd900, 1'b0, 5'd0, 11'd0, 11'd0}, 1'b0, 1'b0, '{5'd0, ACT_DOWN}},
         '{'{32'd1000, 1'b1, 5'd0, 11'd700, 11'd50}, 1'b1, 1'b0, '{5'd0, ACT_DOWN}},
         '{'{32'd1100, 1'b1, 5'd1, 11'd642, 11'd50}, 1'b1, 1'b0, '{5'd0, ACT_DOWN}},
         '{'{32'd1200, 1'b1, 5'd1, 11'd2047, 11'd2047}, 1'b1, 1'b0, '{5'd0, ACT_DOWN}},
         '{'{32'd1300, 1'b1, 5'd1, 11'd0, 11'd0}, 1'b1, 1'b0, '{5'd0, ACT_DOWN}},
         '{'{32'd1400, 1'b1, 5'd1, 11'd735, 11'd50}, 1'b0, 1'b0, '{5'd0, ACT_DOWN}},
         '{'{32'd1500, 1'b1, 5'd1, 11'd700, 11'd395}, 1'b0, 1'b0, '{5'd0, ACT_DOWN}},
         '{'{32'd1600, 1'b1, 5'd1, 11'd800, 11'd450}, 1'b0, 1'b0, '{5'd0, ACT_DOWN}},
         '{'{32'd1700, 1'b1, 5'd1, 11'd700, 11'd150}, 1'b0, 1'b0, '{5'd0, ACT_DOWN}},
         '{'{32'd1800, 1'b0, 5'd0, 11'd0, 11'd0}, 1'b0, 1'b0, '{5'd0, ACT_DOWN}},
         '{'{32'hffff_fff0, 1'b1, 5'd1, 11'd700, 11'd50}, 1'b0, 1'b0, '{5'd0, ACT_DOWN}},
         '{'{32'h0000_0200, 1'b1, 5'd1, 11'd700, 11'd50}, 1'b0, 1'b0, '{5'd0, ACT_DOWN}},
         '{'{32'hffff_ffff, 1'b0, 5'd0, 11'd0, 11'd0}, 1'b0, 1'b0, '{5'd0, ACT_DOWN}}
      };
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) begin
         offer_tick(directed_rows[i].tick, directed_rows[i].typed, directed_rows[i].emits,
                    directed_rows[i].ev);
      end
      settle();
      for (p = 0; p < RANDOM_PHASES; p++) begin
         apply_setting(pick_setting(p));
         // a fixed number of ticks per setting, debounced ones included
         for (tries = 0; tries < TICKS_PER_PHASE; tries++) begin
            offer_tick(make_tick(), 1'b0, 1'b0, no_event);
         end
         settle();
      end
      $display("%0d ticks sent, %0d past debounce, over %0d register settings",
               ticks_accepted, ticks_handled, settings_applied);
      $display("key events checked: %0d down, %0d long press, %0d up",
               act_count[ACT_DOWN], act_count[ACT_LONG], act_count[ACT_UP]);
      if (failures == 0) begin
         $display("touch_keypad_event_generator_tb: clean");
      end else begin
         $display("touch_keypad_event_generator_tb: errors");
      end
      $finish;
   end

endmodule
